// ===== hw/rtl/tdlm_pkg.sv =====
// types, phase constants and helpers for the two-wire display link master
`default_nettype none

package tdlm_pkg;

  localparam int unsigned PHASE_W = 6;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [PHASE_W-1:0] PH_IDLE     = 6'd0;
  localparam logic [PHASE_W-1:0] PH_START    = 6'd1;
  localparam logic [PHASE_W-1:0] PH_START_LO = 6'd2;
  localparam logic [PHASE_W-1:0] PH_BITS     = 6'd3;
  localparam logic [PHASE_W-1:0] PH_LAST_BIT = 6'd26;
  localparam logic [PHASE_W-1:0] PH_ACK_LO   = 6'd27;
  localparam logic [PHASE_W-1:0] PH_ACK_HI   = 6'd28;
  localparam logic [PHASE_W-1:0] PH_STOP     = 6'd29;
  localparam logic [PHASE_W-1:0] PH_STOP_LO  = 6'd30;
  localparam logic [PHASE_W-1:0] PH_STOP_CH  = 6'd31;
  localparam logic [PHASE_W-1:0] PH_END      = 6'd32;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic [1:0] {
    SUB_CLK_LO,
    SUB_DATA,
    SUB_CLK_HI
  } bit_sub_e;

  typedef struct packed {
    logic              req_valid;
    logic              opcode;
    logic [BYTE_W-1:0] tx_byte;
    logic              with_start;
    logic              with_stop;
    logic              dio_level;
  } tdlm_item_t;

  typedef struct packed {
    logic              clk_level;
    logic              dio_out;
    logic              accepted;
    logic              busy_res;
    logic              ack_bit;
    logic [BYTE_W-1:0] rx_byte;
    logic              byte_done;
  } tdlm_res_t;

  // position of a bit phase within its three-phase group
  function automatic bit_sub_e bit_sub(input logic [PHASE_W-1:0] phase);
    bit_sub_e sub;
    case (phase) inside
      6'd3, 6'd6, 6'd9, 6'd12, 6'd15, 6'd18, 6'd21, 6'd24: sub = SUB_CLK_LO;
      6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22, 6'd25: sub = SUB_DATA;
      default: sub = SUB_CLK_HI;
    endcase
    return sub;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tdlm_seq.sv =====
// phase sequencer: pin state, shift register and per-tick result
`default_nettype none

module tdlm_seq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire tdlm_pkg::tdlm_item_t item_i,
  output      tdlm_pkg::tdlm_res_t  res_o
);
  import tdlm_pkg::*;

  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [BYTE_W-1:0]  shift_q, shift_d;
  logic               rd_q, rd_d;
  logic               stop_q, stop_d;
  logic               clk_q, clk_d;
  logic               dio_q, dio_d;
  logic               ack_q, ack_d;
  logic [BYTE_W-1:0]  rx_q, rx_d;

  logic               run;
  logic               idle;
  logic [PHASE_W-1:0] p;
  logic [BYTE_W-1:0]  sr;
  logic               rd;
  logic               sp;
  logic [BYTE_W-1:0]  sr_in;

  always_comb begin
    idle = (phase_q == PH_IDLE);
    run  = item_i.req_valid || !idle;
    if (idle) begin
      p  = item_i.with_start ? PH_START : PH_BITS;
      sr = (item_i.opcode == OP_READ) ? '0 : item_i.tx_byte;
      rd = (item_i.opcode == OP_READ);
      sp = item_i.with_stop;
    end else begin
      p  = phase_q;
      sr = shift_q;
      rd = rd_q;
      sp = stop_q;
    end
    sr_in = {item_i.dio_level, sr[BYTE_W-1:1]};

    phase_d = p + 1'b1;
    shift_d = sr;
    rd_d    = rd;
    stop_d  = sp;
    clk_d   = clk_q;
    dio_d   = dio_q;
    ack_d   = ack_q;
    rx_d    = rx_q;

    if (p == PH_START) begin
      clk_d = 1'b1;
      dio_d = 1'b1;
    end else if (p == PH_START_LO) begin
      dio_d = 1'b0;
    end else if (p >= PH_BITS && p <= PH_LAST_BIT) begin
      case (bit_sub(p))
        SUB_CLK_LO: clk_d = 1'b0;
        SUB_DATA:   dio_d = rd ? 1'b1 : sr[0];
        SUB_CLK_HI: begin
          clk_d = 1'b1;
          if (rd) begin
            shift_d = sr_in;
            if (p == PH_LAST_BIT) begin
              rx_d = sr_in;
            end
          end else begin
            shift_d = {1'b0, sr[BYTE_W-1:1]};
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end else if (p == PH_ACK_LO) begin
      clk_d = 1'b0;
      dio_d = 1'b1;
    end else if (p == PH_ACK_HI) begin
      clk_d   = 1'b1;
      ack_d   = item_i.dio_level;
      phase_d = sp ? PH_STOP : PH_IDLE;
    end else if (p == PH_STOP) begin
      clk_d = 1'b0;
    end else if (p == PH_STOP_LO) begin
      dio_d = 1'b0;
    end else if (p == PH_STOP_CH) begin
      clk_d = 1'b1;
    end else if (p == PH_END) begin
      dio_d   = 1'b1;
      phase_d = PH_IDLE;
    end else begin
      phase_d = PH_IDLE;
    end

    // idle tick with no request leaves everything as it is
    if (!run) begin
      phase_d = phase_q;
      shift_d = shift_q;
      rd_d    = rd_q;
      stop_d  = stop_q;
      clk_d   = clk_q;
      dio_d   = dio_q;
      ack_d   = ack_q;
      rx_d    = rx_q;
    end

    res_o.clk_level = clk_d;
    res_o.dio_out   = dio_d;
    res_o.accepted  = idle && item_i.req_valid;
    res_o.busy_res  = (phase_d != PH_IDLE);
    res_o.ack_bit   = ack_d;
    res_o.rx_byte   = rx_d;
    res_o.byte_done = run && (phase_d == PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      shift_q <= '0;
      rd_q    <= 1'b0;
      stop_q  <= 1'b0;
      clk_q   <= 1'b1;
      dio_q   <= 1'b1;
      ack_q   <= 1'b1;
      rx_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      shift_q <= shift_d;
      rd_q    <= rd_d;
      stop_q  <= stop_d;
      clk_q   <= clk_d;
      dio_q   <= dio_d;
      ack_q   <= ack_d;
      rx_q    <= rx_d;
    end
  end

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_END)
    else $error("phase counter left the schedule");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.byte_done |=> phase_q == PH_IDLE)
    else $error("sequencer not idle after completion");

  a_no_stop_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q == PH_ACK_HI && !stop_q |=> phase_q == PH_IDLE && clk_q)
    else $error("transaction without stop did not end high after ack");

endmodule

`default_nettype wire

// ===== hw/rtl/two_wire_display_link_master.sv =====
// top level: input and result registers around the phase sequencer
// path: a beat accepted on s_axis is held in the input register, then in the result register, and leaves on m_axis
// throughput: one beat per cycle while m_axis_tready is high, one result beat for every input beat
// the sequencer advances one pin phase per beat, unless idle with no request, as the result register drains
// reset: asynchronous active low, clock and data pins released high, sequencer idle
`default_nettype none

module two_wire_display_link_master (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // [0] req_valid, [8:1] tx_byte, [9] with_start, [10] with_stop, [11] dio_level, [15:12] zero
  input  wire logic [15:0] s_axis_tdata,
  // [0] opcode
  input  wire logic        s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [0] clk_level, [1] dio_out, [2] accepted, [3] busy_res, [4] ack_bit,
  // [12:5] rx_byte, [13] byte_done, [15:14] zero
  output      logic [15:0] m_axis_tdata
);
  import tdlm_pkg::*;

  logic       in_vld_q;
  tdlm_item_t in_q;
  tdlm_item_t in_d;
  logic       out_vld_q;
  tdlm_res_t  out_q;
  tdlm_res_t  res;
  logic       adv;
  logic       step;
  logic       s_beat;

  assign adv           = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && adv;
  assign s_axis_tready = !in_vld_q || adv;
  assign s_beat        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.req_valid  = s_axis_tdata[0];
    in_d.opcode     = s_axis_tuser;
    in_d.tx_byte    = s_axis_tdata[8:1];
    in_d.with_start = s_axis_tdata[9];
    in_d.with_stop  = s_axis_tdata[10];
    in_d.dio_level  = s_axis_tdata[11];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_beat) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      in_q <= in_d;
    end
    if (step) begin
      out_q <= res;
    end
  end

  tdlm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_q.byte_done, out_q.rx_byte, out_q.ack_bit,
                          out_q.busy_res, out_q.accepted, out_q.dio_out, out_q.clk_level};

endmodule

`default_nettype wire
